/* hw/rtl/bti_pkg.sv */
// Shared types, constants and helpers for the bilinear table interpolator.
package bti_pkg;

  // Fixed-point format and table geometry
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = 4096;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = 12;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = 7;
  // Corner address: col_cell * count + row_cell + count + 1 for counts up to 127
  localparam int ADDR_W      = 2 * CNT_W;
  // Blend weights run from 0 to one inclusive
  localparam int WT_W        = FRAC_BITS + 1;
  localparam logic [WT_W-1:0] WT_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  // Axis product: 32-bit offset times 32-bit reciprocal step
  localparam int PROD_W      = 64;
  localparam int CELL_RAW_W  = PROD_W - 2 * FRAC_BITS;
  localparam int NCORNER     = 4;
  // Pipeline depth, acceptance to output register
  localparam int NSTAGE      = 10;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ROW_ORIGIN   = 3'd0,
    REG_COL_ORIGIN   = 3'd1,
    REG_ROW_INV_STEP = 3'd2,
    REG_COL_INV_STEP = 3'd3,
    REG_ROW_COUNT    = 3'd4,
    REG_COL_COUNT    = 3'd5
  } reg_index_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] row_coord;
    logic signed [DATA_W-1:0] col_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic                     row_clamped;
    logic                     col_clamped;
  } out_item_t;

  // Per-axis configuration
  typedef struct packed {
    logic signed [DATA_W-1:0] origin;
    logic [DATA_W-1:0]        inv_step;
    logic [CNT_W-1:0]         count;
  } axis_cfg_t;

  // Per-axis grid position after clamping
  typedef struct packed {
    logic [CNT_W-1:0] cell_idx;
    logic [WT_W-1:0]  frac;
    logic             clamped;
  } axis_pos_t;

  // Side data that travels with the corner reads into the blend
  typedef struct packed {
    logic [NCORNER-1:0] in_range;
    logic [WT_W-1:0]    row_frac;
    logic [WT_W-1:0]    col_frac;
    logic               row_clamped;
    logic               col_clamped;
  } blend_ctl_t;

  // Counts below two behave as two
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    eff_count = (c < CNT_W'(2)) ? CNT_W'(2) : c;
  endfunction

endpackage

/* hw/rtl/bti_locate.sv */
// Axis mapping: offset, scale by reciprocal step, split into cell and fraction, clamp.
module bti_locate import bti_pkg::*; (
  input  logic                     clk,
  input  logic [2:0]               en,
  input  logic signed [DATA_W-1:0] coord,
  input  axis_cfg_t                cfg,
  output axis_pos_t                pos
);

  logic signed [DATA_W:0]  off;
  logic [PROD_W-1:0]       prod;
  logic                    prod_neg;
  logic [CNT_W-1:0]        last;
  logic [CELL_RAW_W-1:0]   cell_raw;

  // Stage 1: offset from origin, one bit wider than the coordinate
  always_ff @(posedge clk) begin
    if (en[0]) begin
      off <= {coord[DATA_W-1], coord} - {cfg.origin[DATA_W-1], cfg.origin};
    end
  end

  // Stage 2: grid position; a non-negative offset fits in 32 bits
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_neg <= off[DATA_W];
      prod     <= {{(PROD_W-DATA_W){1'b0}}, off[DATA_W-1:0]} *
                  {{(PROD_W-DATA_W){1'b0}}, cfg.inv_step};
    end
  end

  // Stage 3: floor split and clamp to the first or last full cell
  always_comb begin
    last     = eff_count(cfg.count) - CNT_W'(2);
    cell_raw = prod[PROD_W-1:2*FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (prod_neg) begin
        pos.cell_idx <= '0;
        pos.frac     <= '0;
        pos.clamped  <= 1'b1;
      end else if (cell_raw > {{(CELL_RAW_W-CNT_W){1'b0}}, last}) begin
        pos.cell_idx <= last;
        pos.frac     <= WT_ONE;
        pos.clamped  <= 1'b1;
      end else begin
        pos.cell_idx <= cell_raw[CNT_W-1:0];
        pos.frac     <= {1'b0, prod[2*FRAC_BITS-1:FRAC_BITS]};
        pos.clamped  <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/bti_ram.sv */
// One table bank: single write port, one registered read port.
module bti_ram import bti_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [TBL_AW-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [TBL_AW-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bti_blend.sv */
// Bilinear blend of four corners, truncation toward zero and saturation.
module bti_blend import bti_pkg::*; (
  input  logic                           clk,
  input  logic [4:0]                     en,
  input  logic [NCORNER-1:0][DATA_W-1:0] corner,
  input  blend_ctl_t                     ctl,
  output out_item_t                      result
);

  localparam int P_W   = DATA_W + WT_W + 1;   // corner times weight
  localparam int DSPLIT = 24;                 // low slice of the column difference
  localparam int DHI_W = P_W - DSPLIT;
  localparam int PL_W  = DSPLIT + WT_W;
  localparam int PH_W  = DHI_W + WT_W + 1;
  localparam int S_W   = P_W + FRAC_BITS;
  localparam int Q_W   = S_W - 2 * FRAC_BITS;

  logic signed [DATA_W-1:0] v [NCORNER];
  logic signed [WT_W:0]     rw0, rw1;
  logic signed [P_W-1:0]    p [NCORNER];
  logic signed [P_W-1:0]    a0_7, d_7, a0_8;
  logic [PL_W-1:0]          pl_8;
  logic signed [PH_W-1:0]   ph_8;
  logic signed [DHI_W-1:0]  dhi;
  logic signed [S_W-1:0]    sum_9;
  logic signed [Q_W-1:0]    q, qt;
  logic                     frac_nz;
  logic                     fits;
  logic [WT_W-1:0]          fc_6, fc_7;
  logic [1:0]               flg_6, flg_7, flg_8, flg_9;

  // Corners past the end of the store read as zero
  always_comb begin
    for (int k = 0; k < NCORNER; k++) begin
      v[k] = ctl.in_range[k] ? signed'(corner[k]) : '0;
    end
    rw1 = signed'({1'b0, ctl.row_frac});
    rw0 = signed'({1'b0, WT_ONE - ctl.row_frac});
  end

  // Stage 6: row-axis weights on each corner
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p[0]  <= P_W'(v[0]) * P_W'(rw0);
      p[1]  <= P_W'(v[1]) * P_W'(rw1);
      p[2]  <= P_W'(v[2]) * P_W'(rw0);
      p[3]  <= P_W'(v[3]) * P_W'(rw1);
      fc_6  <= ctl.col_frac;
      flg_6 <= {ctl.row_clamped, ctl.col_clamped};
    end
  end

  // Stage 7: row blends, kept as base plus column difference
  always_ff @(posedge clk) begin
    if (en[1]) begin
      a0_7  <= p[0] + p[1];
      d_7   <= (p[2] + p[3]) - (p[0] + p[1]);
      fc_7  <= fc_6;
      flg_7 <= flg_6;
    end
  end

  // Stage 8: difference times column fraction as two partial products
  assign dhi = d_7[P_W-1:DSPLIT];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a0_8  <= a0_7;
      pl_8  <= PL_W'(d_7[DSPLIT-1:0]) * PL_W'(fc_7);
      ph_8  <= PH_W'(dhi) * PH_W'(signed'({1'b0, fc_7}));
      flg_8 <= flg_7;
    end
  end

  // Stage 9: exact sum with 2*FRAC_BITS fraction bits
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sum_9 <= (S_W'(a0_8) <<< FRAC_BITS) + (S_W'(ph_8) <<< DSPLIT) +
               S_W'({1'b0, pl_8});
      flg_9 <= flg_8;
    end
  end

  // Stage 10: floor, nudge negatives toward zero, saturate
  always_comb begin
    q       = sum_9[S_W-1:2*FRAC_BITS];
    frac_nz = |sum_9[2*FRAC_BITS-1:0];
    qt      = q + Q_W'(sum_9[S_W-1] && frac_nz);
    fits    = (&qt[Q_W-1:DATA_W-1]) || !(|qt[Q_W-1:DATA_W-1]);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (fits) begin
        result.interp_value <= qt[DATA_W-1:0];
      end else if (qt[Q_W-1]) begin
        result.interp_value <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        result.interp_value <= {1'b0, {(DATA_W-1){1'b1}}};
      end
      result.row_clamped <= flg_9[1];
      result.col_clamped <= flg_9[0];
    end
  end

endmodule

/* hw/rtl/bilinear_table_interpolator.sv */
// Top level: config registers, pipeline control, corner addressing and table banks.
//
// Bilinear interpolator over a column-major 2D table of Q16.16 samples.
// in channel: one beat per item. A load beat (cmd = load) writes one table
// entry and gives no result; a query beat gives exactly one out beat with
// the blended value and the per-axis clamp flags, in order.
// cfg channel: register index and data, always ready; write it only while
// no item is in flight.
// Throughput: one item per cycle while the receiver takes results. A
// query's result reaches the output register through ten register stages:
// three for axis mapping, one for corner addresses, one for the table read,
// five for the blend and saturation.
// The table is four copies of a 4096-entry memory, one per corner, all
// written by each load, so the four corner reads happen in the same cycle.
// Reset clears the pipeline valid bits and sets the config registers to
// their defaults; table contents are undefined until loaded.
// When the receiver stalls, stages fill up behind the output register and
// in_ready drops only once every stage holds an item; bubbles collapse.
module bilinear_table_interpolator import bti_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int ADDR_STAGE = 4;
  localparam int READ_STAGE = 5;

  typedef struct packed {
    cmd_t                cmd;
    logic [IDX_W-1:0]    entry_index;
    logic [DATA_W-1:0]   entry_value;
  } load_t;

  logic signed [DATA_W-1:0] row_origin, col_origin;
  logic [DATA_W-1:0]        row_inv_step, col_inv_step;
  logic [CNT_W-1:0]         row_count, col_count;
  axis_cfg_t                row_cfg, col_cfg;
  axis_pos_t                rpos, cpos, rpos_4, cpos_4;

  logic [NSTAGE:1]          vld;
  logic [NSTAGE:1]          en;
  load_t                    ld [1:ADDR_STAGE];

  logic [CNT_W-1:0]         rc;
  logic [ADDR_W-1:0]        base;
  logic [ADDR_W-1:0]        addr_next [NCORNER];
  logic [ADDR_W-1:0]        addr_4 [NCORNER];
  logic [NCORNER-1:0]       in_range;
  logic                     tbl_we;
  blend_ctl_t               ctl_5;
  logic [NCORNER-1:0][DATA_W-1:0] corner;
  out_item_t                result;

  // Config register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_origin   <= '0;
      col_origin   <= '0;
      row_inv_step <= DATA_W'(65536);
      col_inv_step <= DATA_W'(65536);
      row_count    <= CNT_W'(64);
      col_count    <= CNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_ROW_ORIGIN:   row_origin   <= cfg_data;
        REG_COL_ORIGIN:   col_origin   <= cfg_data;
        REG_ROW_INV_STEP: row_inv_step <= cfg_data;
        REG_COL_INV_STEP: col_inv_step <= cfg_data;
        REG_ROW_COUNT:    row_count    <= cfg_data[CNT_W-1:0];
        REG_COL_COUNT:    col_count    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    row_cfg.origin   = row_origin;
    row_cfg.inv_step = row_inv_step;
    row_cfg.count    = row_count;
    col_cfg.origin   = col_origin;
    col_cfg.inv_step = col_inv_step;
    col_cfg.count    = col_count;
  end

  // Stage enables: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld[NSTAGE];
  assign out_data  = result;

  // Valid bits; loads retire at the table write and go no further
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= (k == READ_STAGE) ? (vld[k-1] && ld[ADDR_STAGE].cmd == CMD_QUERY)
                                      : vld[k-1];
        end
      end
    end
  end

  // Load payload rides alongside the axis mapping
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ld[1] <= '{cmd: in_data.cmd, entry_index: in_data.entry_index,
                 entry_value: in_data.entry_value};
    end
    for (int k = 2; k <= ADDR_STAGE; k++) begin
      if (en[k]) begin
        ld[k] <= ld[k-1];
      end
    end
  end

  // Stages 1-3: axis mapping
  bti_locate u_row_locate (
    .clk   (clk),
    .en    (en[3:1]),
    .coord (in_data.row_coord),
    .cfg   (row_cfg),
    .pos   (rpos)
  );

  bti_locate u_col_locate (
    .clk   (clk),
    .en    (en[3:1]),
    .coord (in_data.col_coord),
    .cfg   (col_cfg),
    .pos   (cpos)
  );

  // Stage 4: corner addresses
  always_comb begin
    rc           = eff_count(row_count);
    base         = ADDR_W'(ADDR_W'(cpos.cell_idx) * ADDR_W'(rc)) + ADDR_W'(rpos.cell_idx);
    addr_next[0] = base;
    addr_next[1] = base + ADDR_W'(1);
    addr_next[2] = base + ADDR_W'(rc);
    addr_next[3] = base + ADDR_W'(rc) + ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en[ADDR_STAGE]) begin
      for (int k = 0; k < NCORNER; k++) begin
        addr_4[k] <= addr_next[k];
      end
      rpos_4 <= rpos;
      cpos_4 <= cpos;
    end
  end

  // Stage 5: table read; a load writes here so later queries see it
  always_comb begin
    for (int k = 0; k < NCORNER; k++) begin
      in_range[k] = addr_4[k] < ADDR_W'(TABLE_DEPTH);
    end
    tbl_we = en[READ_STAGE] && vld[ADDR_STAGE] && ld[ADDR_STAGE].cmd == CMD_LOAD &&
             ADDR_W'(ld[ADDR_STAGE].entry_index) < ADDR_W'(TABLE_DEPTH);
  end

  for (genvar g = 0; g < NCORNER; g++) begin : g_bank
    bti_ram u_bank (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (ld[ADDR_STAGE].entry_index[TBL_AW-1:0]),
      .wdata (ld[ADDR_STAGE].entry_value),
      .re    (en[READ_STAGE]),
      .raddr (addr_4[g][TBL_AW-1:0]),
      .rdata (corner[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[READ_STAGE]) begin
      ctl_5.in_range    <= in_range;
      ctl_5.row_frac    <= rpos_4.frac;
      ctl_5.col_frac    <= cpos_4.frac;
      ctl_5.row_clamped <= rpos_4.clamped;
      ctl_5.col_clamped <= cpos_4.clamped;
    end
  end

  // Stages 6-10: blend and output register
  bti_blend u_blend (
    .clk    (clk),
    .en     (en[NSTAGE:READ_STAGE+1]),
    .corner (corner),
    .ctl    (ctl_5),
    .result (result)
  );

endmodule

/* hw/rtl/bti_checker.sv */
// Port-level checks for the bilinear table interpolator, bound to the top level.
module bti_checker import bti_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  // A stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat shown right after reset");

  // With the output register empty, no stage can block the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // Config writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config beat not taken");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (.*);

/* test/tb_bilinear_table_interpolator.sv */
// Testbench for the bilinear table interpolator: random and directed loads and queries, self-checked.
module tb_bilinear_table_interpolator;
  import bti_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [WT_W-1:0]          UNIT_WT = 17'h1_0000;
  localparam logic signed [79:0]       BLEND_SCALE = 80'sh1_0000_0000;
  localparam int                       FILL_COUNT = 128;

  // Shadow of the block: table contents and register file
  logic signed [DATA_W-1:0] table_shadow [TABLE_DEPTH];
  bit                       written [TABLE_DEPTH];
  logic signed [DATA_W-1:0] row_origin_q = '0;
  logic signed [DATA_W-1:0] col_origin_q = '0;
  logic [DATA_W-1:0]        row_inv_step_q = 32'd65536;
  logic [DATA_W-1:0]        col_inv_step_q = 32'd65536;
  logic [CNT_W-1:0]         row_count_q = 7'd64;
  logic [CNT_W-1:0]         col_count_q = 7'd64;

  out_item_t pending_results [$];
  int        mismatch_count = 0;
  int        results_checked = 0;
  int        loads_sent = 0;
  int        queries_sent = 0;
  int        settings_used = 0;
  bit        no_gaps = 1'b0;

  bilinear_table_interpolator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Grid position of one axis: cell, blend weight of the next cell, clamp flag
  function automatic void map_axis(input logic signed [DATA_W-1:0] coord,
                                   input logic signed [DATA_W-1:0] origin,
                                   input logic [DATA_W-1:0] inv_step,
                                   input int unsigned count,
                                   output int unsigned cell_idx,
                                   output logic [WT_W-1:0] frac,
                                   output logic flag);
    logic signed [33:0] offset;
    logic [65:0]        pos;
    int unsigned        last;
    offset = coord;
    offset = offset - origin;
    last = count - 2;
    flag = 1'b0;
    if (offset < 0) begin
      // below the origin: first cell, no blend toward the next one
      cell_idx = 0;
      frac = '0;
      flag = 1'b1;
    end else begin
      pos = offset[32:0] * inv_step;
      if (pos[65:32] > last) begin
        // past the last full cell: sit on the far edge
        cell_idx = last;
        frac = UNIT_WT;
        flag = 1'b1;
      end else begin
        cell_idx = int'(pos[39:32]);
        frac = {1'b0, pos[31:16]};
      end
    end
  endfunction

  // Table read; addresses past the store read as zero
  function automatic logic signed [DATA_W-1:0] corner_value(input int unsigned addr);
    corner_value = (addr >= TABLE_DEPTH) ? '0 : table_shadow[addr];
  endfunction

  // Exact bilinear blend, truncated toward zero and saturated
  function automatic out_item_t blend_lookup(input in_item_t q);
    int unsigned        rc, cc, rcell, ccell, base;
    logic [WT_W-1:0]    rfr, cfr;
    logic               rflag, cflag;
    logic signed [79:0] wr0, wr1, wc0, wc1, acc, quot;
    out_item_t          res;
    rc = (row_count_q < 2) ? 2 : row_count_q;
    cc = (col_count_q < 2) ? 2 : col_count_q;
    map_axis(q.row_coord, row_origin_q, row_inv_step_q, rc, rcell, rfr, rflag);
    map_axis(q.col_coord, col_origin_q, col_inv_step_q, cc, ccell, cfr, cflag);
    base = ccell * rc + rcell;
    wr1 = rfr;
    wr0 = 80'sd65536 - wr1;
    wc1 = cfr;
    wc0 = 80'sd65536 - wc1;
    acc = corner_value(base) * wr0 * wc0
        + corner_value(base + 1) * wr1 * wc0
        + corner_value(base + rc) * wr0 * wc1
        + corner_value(base + rc + 1) * wr1 * wc1;
    quot = acc / BLEND_SCALE;
    if (quot > 80'sd2147483647) quot = 80'sd2147483647;
    else if (quot < -80'sd2147483648) quot = -80'sd2147483648;
    res.interp_value = quot[31:0];
    res.row_clamped  = rflag;
    res.col_clamped  = cflag;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Receiver stalls about 28% of cycles, never while no_gaps is set
  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(99) >= 28);
  end

  // Compare each output beat with the oldest pending result
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.interp_value, '0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.interp_value !== want.interp_value)
          report_mismatch("interp_value", out_data.interp_value, want.interp_value);
        if (out_data.row_clamped !== want.row_clamped)
          report_mismatch("row_clamped", 32'(out_data.row_clamped), 32'(want.row_clamped));
        if (out_data.col_clamped !== want.col_clamped)
          report_mismatch("col_clamped", 32'(out_data.col_clamped), 32'(want.col_clamped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one beat; the shadow is updated at the accepting edge
  task automatic send_item(input in_item_t item);
    while (!no_gaps && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.cmd == CMD_LOAD) begin
      table_shadow[item.entry_index] = item.entry_value;
      written[item.entry_index] = 1'b1;
      loads_sent++;
    end else begin
      pending_results.push_back(blend_lookup(item));
      queries_sent++;
    end
  endtask

  function automatic in_item_t make_load(input int unsigned idx,
                                         input logic signed [DATA_W-1:0] value);
    in_item_t item;
    item.cmd         = CMD_LOAD;
    item.entry_index = IDX_W'(idx);
    item.entry_value = value;
    item.row_coord   = $urandom;
    item.col_coord   = $urandom;
    return item;
  endfunction

  function automatic in_item_t make_query(input logic signed [DATA_W-1:0] row,
                                          input logic signed [DATA_W-1:0] col);
    in_item_t item;
    item.cmd         = CMD_QUERY;
    item.entry_index = IDX_W'($urandom);
    item.entry_value = $urandom;
    item.row_coord   = row;
    item.col_coord   = col;
    return item;
  endfunction

  // Sample value: mostly random, sometimes a full-scale extreme
  function automatic logic signed [DATA_W-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return VAL_MAX;
    if (roll < 16) return VAL_MIN;
    return $urandom;
  endfunction

  // Query beat; any corner in the store that was never loaded gets a load first
  task automatic send_query(input logic signed [DATA_W-1:0] row,
                            input logic signed [DATA_W-1:0] col);
    int unsigned     rc, cc, rcell, ccell, base;
    int unsigned     addr [NCORNER];
    logic [WT_W-1:0] rfr, cfr;
    logic            rflag, cflag;
    rc = (row_count_q < 2) ? 2 : row_count_q;
    cc = (col_count_q < 2) ? 2 : col_count_q;
    map_axis(row, row_origin_q, row_inv_step_q, rc, rcell, rfr, rflag);
    map_axis(col, col_origin_q, col_inv_step_q, cc, ccell, cfr, cflag);
    base = ccell * rc + rcell;
    addr = '{base, base + 1, base + rc, base + rc + 1};
    foreach (addr[k]) begin
      if (addr[k] < TABLE_DEPTH && !written[addr[k]])
        send_item(make_load(addr[k], pick_sample()));
    end
    send_item(make_query(row, col));
  endtask

  // Coordinate on one axis: mostly on the grid, some below, near or past the end
  function automatic logic signed [DATA_W-1:0] pick_coord(
      input logic signed [DATA_W-1:0] origin, input logic [DATA_W-1:0] inv_step,
      input logic [CNT_W-1:0] count);
    logic [63:0] span, offset;
    int unsigned eff, roll;
    eff  = (count < 2) ? 2 : count;
    roll = $urandom_range(99);
    if (inv_step == 0) span = 64'hFFFF_FFFF;
    else span = (64'(eff - 1) << 32) / inv_step;
    if (span > 64'h1_FFFF_FFFF) span = 64'h1_FFFF_FFFF;
    if (roll < 12) return $urandom;
    if (roll < 22) return origin - DATA_W'($urandom_range(1, 1 << 20));
    if (roll < 32) offset = span + $urandom_range(0, 64) - 32;
    else offset = {$urandom, $urandom} % (span + 64'd1);
    return origin + offset[31:0];
  endfunction

  // Wait until every query has been answered and the pipeline is empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NSTAGE + 4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROW_ORIGIN:   row_origin_q   = value;
      REG_COL_ORIGIN:   col_origin_q   = value;
      REG_ROW_INV_STEP: row_inv_step_q = value;
      REG_COL_INV_STEP: col_inv_step_q = value;
      REG_ROW_COUNT:    row_count_q    = value[CNT_W-1:0];
      REG_COL_COUNT:    col_count_q    = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [DATA_W-1:0] row_org, input logic [DATA_W-1:0] col_org,
                              input logic [DATA_W-1:0] row_inv, input logic [DATA_W-1:0] col_inv,
                              input logic [CNT_W-1:0] row_cnt, input logic [CNT_W-1:0] col_cnt);
    drain_pipeline();
    write_reg(REG_ROW_ORIGIN, row_org);
    write_reg(REG_COL_ORIGIN, col_org);
    write_reg(REG_ROW_INV_STEP, row_inv);
    write_reg(REG_COL_INV_STEP, col_inv);
    write_reg(REG_ROW_COUNT, 32'(row_cnt));
    write_reg(REG_COL_COUNT, 32'(col_cnt));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mixed random traffic under the current register setting
  task automatic run_random_mix(input int n_items, input int load_pct);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < load_pct)
        send_item(make_load($urandom_range(TABLE_DEPTH - 1), pick_sample()));
      else
        send_query(pick_coord(row_origin_q, row_inv_step_q, row_count_q),
                   pick_coord(col_origin_q, col_inv_step_q, col_count_q));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First grid columns written up front; queries load the rest on demand
  task automatic test_table_fill();
    for (int i = 0; i < FILL_COUNT; i++) send_item(make_load(i, pick_sample()));
  endtask

  // Extremes of value and coordinate under the reset setting
  task automatic test_directed_corners();
    send_item(make_load(0, VAL_MAX));
    send_item(make_load(1, VAL_MIN));
    send_item(make_load(64, VAL_MAX));
    send_item(make_load(65, VAL_MIN));
    send_item(make_load(4094, VAL_MAX));
    send_item(make_load(4095, VAL_MIN));
    send_query(32'sh0, 32'sh0);
    // half-way between opposite extremes: rounds toward zero
    send_query(32'sh8000, 32'sh8000);
    send_query(32'sh8000, 32'sh0);
    send_query(32'sh0000_FFFF, 32'sh0000_FFFF);
    // below origin on each axis
    send_query(-32'sh1, 32'sh0);
    send_query(32'sh0, -32'sh1);
    send_query(VAL_MIN, VAL_MIN);
    // past the last cell, far corner entry at full weight
    send_query(VAL_MAX, VAL_MAX);
    send_query(32'sh003E_0000, 32'sh003E_0000);
    send_query(32'sh003E_FFFF, 32'sh0000_8000);
    send_query(32'sh003F_0000, 32'sh0);
    send_query(32'sh0, 32'sh003F_0000);
    send_query(VAL_MAX, 32'sh0001_0000);
    // load immediately followed by a query of the same entry
    send_item(make_load(0, 32'sh1234_5678));
    send_query(32'sh0, 32'sh0);
  endtask

  // Long stretch with neither side idling
  task automatic test_back_to_back();
    drain_pipeline();
    no_gaps = 1'b1;
    run_random_mix(80, 20);
    drain_pipeline();
    no_gaps = 1'b0;
  endtask

  // Sweep of register settings, extremes first, then random ones, then the reset setting
  task automatic test_config_sweep();
    apply_config(-32'sd327680, 32'sd196608, 32'd131072, 32'd32768, 7'd16, 7'd8);
    run_random_mix(60, 20);
    // smallest grid with extreme origins
    apply_config(32'h7FFF_0000, 32'h8000_0000, 32'd65536, 32'd65536, 7'd2, 7'd2);
    run_random_mix(40, 20);
    // counts below two behave as two
    apply_config(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd0, 7'd1);
    run_random_mix(40, 20);
    // reciprocal step extremes
    apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 7'd64, 7'd64);
    run_random_mix(60, 20);
    // zero reciprocal step pins both axes to the first cell
    apply_config(32'h0, 32'h0, 32'd0, 32'd0, 7'd40, 7'd12);
    run_random_mix(40, 20);
    // counts large enough that corner reads run past the store
    apply_config(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd127, 7'd100);
    run_random_mix(60, 20);
    apply_config(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd127, 7'd127);
    run_random_mix(40, 20);
    repeat (4) begin
      apply_config($urandom_range(0, 1 << 25) - (1 << 24), $urandom_range(0, 1 << 25) - (1 << 24),
                   $urandom_range(1 << 12, 1 << 20), $urandom_range(1 << 12, 1 << 20),
                   $urandom_range(2, 64), $urandom_range(2, 64));
      run_random_mix(40, 25);
    end
    // back to the reset setting
    apply_config(32'h0, 32'h0, 32'd65536, 32'd65536, 7'd64, 7'd64);
    run_random_mix(40, 20);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_fill();
    test_directed_corners();
    test_back_to_back();
    test_config_sweep();
    drain_pipeline();
    foreach (pending_results[i])
      report_mismatch("result never arrived", '0, pending_results[i].interp_value);
    $display("Covered %0d loads and %0d queries over %0d register settings.",
             loads_sent, queries_sent, settings_used);
    $display("%0d results checked, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("Run limit reached with %0d results pending.", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bti_pkg.sv
hw/rtl/bti_locate.sv
hw/rtl/bti_ram.sv
hw/rtl/bti_blend.sv
hw/rtl/bilinear_table_interpolator.sv
hw/rtl/bti_checker.sv
test/tb_bilinear_table_interpolator.sv
